// ===== design/polyline_point_thinning_assert.svh =====
// Assertion macros for the port-level checker of the polyline point thinning block.
`ifndef POLYLINE_POINT_THINNING_ASSERT_SVH
`define POLYLINE_POINT_THINNING_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PTP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptp assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptp assertion failed");

`endif

// ===== design/ptp_pkg.sv =====
// Shared types and constants of the polyline point thinning block.
`default_nettype none

package ptp_pkg;

  localparam int unsigned PIXEL_FRAC_BITS = 8;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned CFG_IDX_W       = 3;

  // register reset values
  localparam logic signed [31:0] RST_ORIGIN_LON  = 32'sd49612600;
  localparam logic signed [30:0] RST_TOP_LAT     = 31'sd556733600;
  localparam logic        [31:0] RST_LON_SCALE   = 32'd10943195;
  localparam logic        [31:0] RST_LAT_SCALE   = 32'd17131727;
  localparam logic        [31:0] RST_MIN_DIST_SQ = 32'd53084;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_LON  = 3'd0,
    REG_TOP_LAT     = 3'd1,
    REG_LON_SCALE   = 3'd2,
    REG_LAT_SCALE   = 3'd3,
    REG_MIN_DIST_SQ = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    CMD_POINT = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  // projection settings seen by the front end
  typedef struct packed {
    logic signed [31:0] origin_lon;
    logic signed [30:0] top_lat;
    logic        [31:0] lon_scale;
    logic        [31:0] lat_scale;
  } proj_cfg_t;

  // one classified command in the queue
  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pt_entry_t;

endpackage

`default_nettype wire

// ===== design/ptp_front.sv =====
// Front end: accepts commands and projects points to saturated fixed-point pixels.
`default_nettype none

module ptp_front #(
  parameter int unsigned PIXEL_FRAC_BITS = ptp_pkg::PIXEL_FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptp_pkg::proj_cfg_t  cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_cmd_i,
  input  logic signed [31:0]  in_lon_i,
  input  logic signed [30:0]  in_lat_i,
  output logic                push_o,
  output ptp_pkg::pt_entry_t  push_data_o,
  input  logic                full_i
);
  import ptp_pkg::*;

  localparam int unsigned SH = 40 - PIXEL_FRAC_BITS;
  localparam logic [64:0] HALF = 65'd1 << (SH - 1);

  // sign application to the rounded magnitude and saturation to the signed 32-bit range
  function automatic logic [31:0] round_sat(input logic neg, input logic [64:0] qe);
    logic [31:0] r;
    if (neg) begin
      if (qe >= 65'h80000000) r = 32'h80000000;
      else                    r = 32'd0 - qe[31:0];
    end else begin
      if (qe > 65'h7FFFFFFF)  r = 32'h7FFFFFFF;
      else                    r = qe[31:0];
    end
    return r;
  endfunction

  logic        en;

  logic        s1_v_q, s2_v_q, s3_v_q;
  cmd_e        s1_cmd_q, s2_cmd_q;
  logic        s1_negx_q, s1_negy_q, s2_negx_q, s2_negy_q;
  logic [32:0] s1_magx_q, s1_magy_q;
  logic [63:0] s2_prodx_q, s2_prody_q;
  logic        s2_hix_q, s2_hiy_q;
  pt_entry_t   s3_q;

  logic [32:0] diffx, diffy, magx, magy;
  logic [64:0] sumx, sumy, qex, qey;

  // pipeline moves whenever the last stage can drain
  assign en          = !s3_v_q || !full_i;
  assign in_ready_o  = en;
  assign push_o      = s3_v_q && !full_i;
  assign push_data_o = s3_q;

  // stage 1: coordinate offsets and their magnitudes
  always_comb begin
    diffx = {in_lon_i[31], in_lon_i} - {cfg_i.origin_lon[31], cfg_i.origin_lon};
    diffy = {{2{cfg_i.top_lat[30]}}, cfg_i.top_lat} - {{2{in_lat_i[30]}}, in_lat_i};
    magx  = diffx[32] ? (33'd0 - diffx) : diffx;
    magy  = diffy[32] ? (33'd0 - diffy) : diffy;
  end

  // stage 3: fold in the top magnitude bit and the rounding half, then shift
  always_comb begin
    sumx = {1'b0, s2_prodx_q} + (s2_hix_q ? {1'b0, cfg_i.lon_scale, 32'd0} : 65'd0) + HALF;
    sumy = {1'b0, s2_prody_q} + (s2_hiy_q ? {1'b0, cfg_i.lat_scale, 32'd0} : 65'd0) + HALF;
    qex  = sumx >> SH;
    qey  = sumy >> SH;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_cmd_q   <= cmd_e'(in_cmd_i);
      s1_negx_q  <= diffx[32];
      s1_negy_q  <= diffy[32];
      s1_magx_q  <= magx;
      s1_magy_q  <= magy;

      s2_cmd_q   <= s1_cmd_q;
      s2_negx_q  <= s1_negx_q;
      s2_negy_q  <= s1_negy_q;
      s2_hix_q   <= s1_magx_q[32];
      s2_hiy_q   <= s1_magy_q[32];
      s2_prodx_q <= 64'(s1_magx_q[31:0]) * 64'(cfg_i.lon_scale);
      s2_prody_q <= 64'(s1_magy_q[31:0]) * 64'(cfg_i.lat_scale);

      s3_q.cmd   <= s2_cmd_q;
      s3_q.x     <= round_sat(s2_negx_q, qex);
      s3_q.y     <= round_sat(s2_negy_q, qey);
    end
  end

endmodule

`default_nettype wire

// ===== design/ptp_queue.sv =====
// Short register queue between the front end and the back end.
`default_nettype none

module ptp_queue #(
  parameter int unsigned DEPTH = ptp_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ptp_pkg::pt_entry_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output ptp_pkg::pt_entry_t head_o,
  output logic               empty_o
);
  import ptp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pt_entry_t          mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (!do_push && do_pop) count_q <= count_q - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

// ===== design/ptp_back.sv =====
// Back end: distance test against the last painted point, hold and flush, result register.
`default_nettype none

module ptp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        min_dist_sq_i,
  input  logic               empty_i,
  input  ptp_pkg::pt_entry_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic               out_starts_o,
  output logic               out_flush_o
);
  import ptp_pkg::*;

  typedef enum logic [1:0] {
    B_FETCH,
    B_SQUARE,
    B_DECIDE
  } state_e;

  state_e             state_q;
  pt_entry_t          cur_q;
  logic [16:0]        ax_q, ay_q;
  logic               big_q;
  logic [33:0]        sqx_q, sqy_q;
  logic signed [31:0] painted_x_q, painted_y_q, held_x_q, held_y_q;
  logic               painted_valid_q, held_pending_q;
  logic               out_valid_q, out_starts_q, out_flush_q;
  logic signed [31:0] out_x_q, out_y_q;

  logic [32:0] dx, dy, adx, ady;
  logic        big, far, slot_free, emit;

  assign pop_o        = (state_q == B_FETCH) && !empty_i;
  assign out_valid_o  = out_valid_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign out_starts_o = out_starts_q;
  assign out_flush_o  = out_flush_q;

  // offsets to the last painted point, taken at the queue head
  always_comb begin
    dx  = {head_i.x[31], head_i.x} - {painted_x_q[31], painted_x_q};
    dy  = {head_i.y[31], head_i.y} - {painted_y_q[31], painted_y_q};
    adx = dx[32] ? (33'd0 - dx) : dx;
    ady = dy[32] ? (33'd0 - dy) : dy;
    big = (adx[32:17] != '0) || (ady[32:17] != '0);
  end

  assign far       = big_q || (({1'b0, sqx_q} + {1'b0, sqy_q}) >= {3'd0, min_dist_sq_i});
  assign slot_free = !out_valid_q || out_ready_i;

  // a result leaves the decide step once the result register is free
  assign emit = (state_q == B_DECIDE) && slot_free &&
                ((cur_q.cmd == CMD_FLUSH) ? held_pending_q : (!painted_valid_q || far));

  // sequencer, point state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= B_FETCH;
      cur_q           <= '0;
      ax_q            <= '0;
      ay_q            <= '0;
      big_q           <= 1'b0;
      sqx_q           <= '0;
      sqy_q           <= '0;
      painted_x_q     <= '0;
      painted_y_q     <= '0;
      painted_valid_q <= 1'b0;
      held_x_q        <= '0;
      held_y_q        <= '0;
      held_pending_q  <= 1'b0;
      out_valid_q     <= 1'b0;
      out_x_q         <= '0;
      out_y_q         <= '0;
      out_starts_q    <= 1'b0;
      out_flush_q     <= 1'b0;
    end else begin
      out_valid_q <= emit || (out_valid_q && !out_ready_i);

      case (state_q)
        B_FETCH: begin
          if (!empty_i) begin
            cur_q   <= head_i;
            ax_q    <= adx[16:0];
            ay_q    <= ady[16:0];
            big_q   <= big;
            state_q <= B_SQUARE;
          end
        end

        B_SQUARE: begin
          sqx_q   <= 34'(ax_q) * 34'(ax_q);
          sqy_q   <= 34'(ay_q) * 34'(ay_q);
          state_q <= B_DECIDE;
        end

        B_DECIDE: begin
          if (cur_q.cmd == CMD_FLUSH) begin
            // end of ring: paint the held point if any, then restart
            if (!held_pending_q) begin
              painted_valid_q <= 1'b0;
              state_q         <= B_FETCH;
            end else if (slot_free) begin
              out_x_q         <= held_x_q;
              out_y_q         <= held_y_q;
              out_starts_q    <= !painted_valid_q;
              out_flush_q     <= 1'b1;
              painted_x_q     <= held_x_q;
              painted_y_q     <= held_y_q;
              painted_valid_q <= 1'b0;
              held_pending_q  <= 1'b0;
              state_q         <= B_FETCH;
            end
          end else if (!painted_valid_q || far) begin
            // paint this point once the result register is free
            if (slot_free) begin
              out_x_q         <= cur_q.x;
              out_y_q         <= cur_q.y;
              out_starts_q    <= !painted_valid_q;
              out_flush_q     <= 1'b0;
              painted_x_q     <= cur_q.x;
              painted_y_q     <= cur_q.y;
              painted_valid_q <= 1'b1;
              held_x_q        <= cur_q.x;
              held_y_q        <= cur_q.y;
              held_pending_q  <= 1'b0;
              state_q         <= B_FETCH;
            end
          end else begin
            // too close: keep it for a later flush
            held_x_q       <= cur_q.x;
            held_y_q       <= cur_q.y;
            held_pending_q <= 1'b1;
            state_q        <= B_FETCH;
          end
        end

        default: state_q <= B_FETCH;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/polyline_point_thinning.sv =====
// Top level of the polyline point thinning block: registers, front end, queue, back end.
//
// Input stream (s_axis_*): one beat per command. tuser is the command (0 point,
// 1 end of ring); tdata carries longitude in bits 31:0 and latitude in 62:32.
// Output stream (m_axis_*): zero or one beat per command, the projected point in
// Q.PIXEL_FRAC_BITS pixels with move/line and flush flags in tuser.
// Configuration channel (cfg_*): one register write per beat, always ready;
// write only while the block is idle.
// The back end takes one command at a time through its distance loop (offset,
// square, compare) against the last painted point and fetches no new command
// until it is done with the last. The front end's three projection stages
// take a beat every cycle until the queue fills.
// Reset: registers return to their default map, the ring state clears and no
// beat is pending. When the receiver stalls, the result register holds its beat,
// the back end waits on the next result, then the queue and the front end fill
// and s_axis_tready drops.
`default_nettype none

module polyline_point_thinning #(
  parameter int unsigned PIXEL_FRAC_BITS = ptp_pkg::PIXEL_FRAC_BITS,
  parameter int unsigned QUEUE_DEPTH     = ptp_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ptp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  // command stream in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,  // lon[31:0], lat[62:32], zero[63]
  input  logic                            s_axis_tuser,  // cmd
  // point stream out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [63:0]                     m_axis_tdata,  // px_x[31:0], px_y[63:32]
  output logic [1:0]                      m_axis_tuser   // starts_path[0], from_flush[1]
);
  import ptp_pkg::*;

  proj_cfg_t          proj_cfg_q;
  logic [31:0]        min_dist_sq_q;
  logic               push, full, pop, empty;
  pt_entry_t          push_data, head;
  logic signed [31:0] out_x, out_y;
  logic               out_starts, out_flush;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_cfg_q.origin_lon <= RST_ORIGIN_LON;
      proj_cfg_q.top_lat    <= RST_TOP_LAT;
      proj_cfg_q.lon_scale  <= RST_LON_SCALE;
      proj_cfg_q.lat_scale  <= RST_LAT_SCALE;
      min_dist_sq_q         <= RST_MIN_DIST_SQ;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ORIGIN_LON:  proj_cfg_q.origin_lon <= cfg_data_i;
        REG_TOP_LAT:     proj_cfg_q.top_lat    <= cfg_data_i[30:0];
        REG_LON_SCALE:   proj_cfg_q.lon_scale  <= cfg_data_i;
        REG_LAT_SCALE:   proj_cfg_q.lat_scale  <= cfg_data_i;
        REG_MIN_DIST_SQ: min_dist_sq_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ptp_front #(
    .PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (proj_cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_lon_i    (s_axis_tdata[31:0]),
    .in_lat_i    (s_axis_tdata[62:32]),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  ptp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  ptp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .min_dist_sq_i (min_dist_sq_q),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_x_o       (out_x),
    .out_y_o       (out_y),
    .out_starts_o  (out_starts),
    .out_flush_o   (out_flush)
  );

  assign m_axis_tdata = {out_y, out_x};
  assign m_axis_tuser = {out_flush, out_starts};

endmodule

`default_nettype wire

// ===== design/ptp_checker.sv =====
// Port-level checker for the polyline point thinning block, bound to the top level.
`default_nettype none

`include "polyline_point_thinning_assert.svh"

module ptp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser
);

  // a stalled result beat stays put
  `PTP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // a flushed point always continues a path already started
  `PTP_ASSERT_SAME(a_flush_is_line, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0])

  // two flush beats never follow each other directly
  `PTP_ASSERT_NEXT(a_no_double_flush, m_axis_tvalid && m_axis_tready && m_axis_tuser[1], !(m_axis_tvalid && m_axis_tuser[1]))

endmodule

bind polyline_point_thinning ptp_checker u_ptp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== dv/polyline_point_thinning_checker.sv =====
// Checker for the polyline point thinning block: predicts painted points and compares beats.
`timescale 1ns / 1ps

module polyline_point_thinning_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [ptp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  // command stream into the block
  input  logic                          s_valid_i,
  input  logic                          s_ready_i,
  input  logic [63:0]                   s_data_i,   // lon[31:0], lat[62:32], zero[63]
  input  logic                          s_user_i,   // cmd
  // point stream out of the block
  input  logic                          m_valid_i,
  input  logic                          m_ready_i,
  input  logic [63:0]                   m_data_i,   // px_x[31:0], px_y[63:32]
  input  logic [1:0]                    m_user_i,   // starts_path[0], from_flush[1]
  // status toward the testbench top
  output int                            err_cnt_o,
  output int                            pending_o,
  output int                            painted_o,
  output int                            flushed_o
);

  import ptp_pkg::*;

  localparam int          SHIFT      = 40 - PIXEL_FRAC_BITS;
  localparam logic [32:0] NEAR_LIMIT = 33'd131072;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               starts_path;
    logic               from_flush;
  } painted_pt_t;

  // map settings as the block should hold them
  logic signed [31:0] map_origin_lon;
  logic signed [30:0] map_top_lat;
  logic        [31:0] map_lon_scale;
  logic        [31:0] map_lat_scale;
  logic        [31:0] map_min_dist_sq;

  // ring state: last painted point and the point held back
  logic signed [31:0] last_x;
  logic signed [31:0] last_y;
  logic               last_valid;
  logic signed [31:0] held_x;
  logic signed [31:0] held_y;
  logic               held_pending;

  painted_pt_t painted_queue[$];
  int          err_cnt;
  int          painted_cnt;
  int          flushed_cnt;

  // offset times scale, rounded half away from zero, saturated to 32 bits
  function automatic logic signed [31:0] project_axis(logic [32:0] offset, logic [31:0] scale);
    logic [32:0] mag;
    logic [63:0] prod;
    logic [63:0] q;
    mag  = offset[32] ? (~offset + 33'd1) : offset;
    prod = 64'(mag) * 64'(scale);
    q    = (prod >> SHIFT) + 64'(prod[SHIFT-1]);
    if (offset[32]) begin
      return (q >= 64'h8000_0000) ? 32'h8000_0000 : -q[31:0];
    end
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  // squared distance to the last painted point reaches the threshold, or an axis offset reaches NEAR_LIMIT
  function automatic logic far_from_last(logic signed [31:0] x, logic signed [31:0] y);
    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] ax;
    logic [32:0] ay;
    logic [63:0] dist_sq;
    dx = {x[31], x} - {last_x[31], last_x};
    dy = {y[31], y} - {last_y[31], last_y};
    ax = dx[32] ? (~dx + 33'd1) : dx;
    ay = dy[32] ? (~dy + 33'd1) : dy;
    if (ax >= NEAR_LIMIT || ay >= NEAR_LIMIT) begin
      return 1'b1;
    end
    dist_sq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
    return dist_sq >= 64'(map_min_dist_sq);
  endfunction

  task automatic paint(logic signed [31:0] x, logic signed [31:0] y, logic flush);
    painted_pt_t pt;
    pt = '{x: x, y: y, starts_path: !last_valid, from_flush: flush};
    painted_queue.insert(painted_queue.size(), pt);
    last_x     = x;
    last_y     = y;
    last_valid = 1'b1;
  endtask

  // one accepted command: update ring state, queue the point it paints
  task automatic thin_command(logic [63:0] data, logic user);
    logic signed [31:0] lon;
    logic signed [30:0] lat;
    logic signed [31:0] x;
    logic signed [31:0] y;
    if (cmd_e'(user) == CMD_FLUSH) begin
      if (held_pending) begin
        paint(held_x, held_y, 1'b1);
      end
      last_valid   = 1'b0;
      held_pending = 1'b0;
    end else begin
      lon = data[31:0];
      lat = data[62:32];
      x = project_axis({lon[31], lon} - {map_origin_lon[31], map_origin_lon}, map_lon_scale);
      y = project_axis({{2{map_top_lat[30]}}, map_top_lat} - {{2{lat[30]}}, lat},
                       map_lat_scale);
      held_x = x;
      held_y = y;
      if (!last_valid || far_from_last(x, y)) begin
        paint(x, y, 1'b0);
        held_pending = 1'b0;
      end else begin
        held_pending = 1'b1;
      end
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    painted_pt_t want;
    painted_pt_t seen;
    if (!rst_ni) begin
      map_origin_lon  = RST_ORIGIN_LON;
      map_top_lat     = RST_TOP_LAT;
      map_lon_scale   = RST_LON_SCALE;
      map_lat_scale   = RST_LAT_SCALE;
      map_min_dist_sq = RST_MIN_DIST_SQ;
      last_x          = '0;
      last_y          = '0;
      last_valid      = 1'b0;
      held_x          = '0;
      held_y          = '0;
      held_pending    = 1'b0;
      painted_queue.delete();
      err_cnt         = 0;
      painted_cnt     = 0;
      flushed_cnt     = 0;
    end else begin
      // output beat first: a command accepted now cannot paint in the same cycle
      if (m_valid_i && m_ready_i) begin
        seen = '{x: m_data_i[31:0], y: m_data_i[63:32],
                 starts_path: m_user_i[0], from_flush: m_user_i[1]};
        painted_cnt++;
        if (seen.from_flush) begin
          flushed_cnt++;
        end
        if (painted_queue.size() == 0) begin
          if (err_cnt < 10) begin
            $display("unexpected point beat: x=%0d y=%0d move=%0b flush=%0b",
                     seen.x, seen.y, seen.starts_path, seen.from_flush);
          end
          err_cnt++;
        end else begin
          want = painted_queue.pop_front();
          if (seen.x !== want.x || seen.y !== want.y ||
              seen.starts_path !== want.starts_path || seen.from_flush !== want.from_flush) begin
            if (err_cnt < 10) begin
              $display("point %0d mismatch: expected x=%0d y=%0d move=%0b flush=%0b",
                       painted_cnt, want.x, want.y, want.starts_path, want.from_flush);
              $display("  got x=%0d y=%0d move=%0b flush=%0b",
                       seen.x, seen.y, seen.starts_path, seen.from_flush);
            end
            err_cnt++;
          end
        end
      end
      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_ORIGIN_LON:  map_origin_lon  = cfg_data_i;
          REG_TOP_LAT:     map_top_lat     = cfg_data_i[30:0];
          REG_LON_SCALE:   map_lon_scale   = cfg_data_i;
          REG_LAT_SCALE:   map_lat_scale   = cfg_data_i;
          REG_MIN_DIST_SQ: map_min_dist_sq = cfg_data_i;
          default: ;
        endcase
      end
      // command beat
      if (s_valid_i && s_ready_i) begin
        thin_command(s_data_i, s_user_i);
      end
    end
    err_cnt_o <= err_cnt;
    pending_o <= painted_queue.size();
    painted_o <= painted_cnt;
    flushed_o <= flushed_cnt;
  end

endmodule

// ===== dv/polyline_point_thinning_tb.sv =====
// Testbench top for the polyline point thinning block: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module polyline_point_thinning_tb;

  import ptp_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int NUM_PHASES    = 9;
  localparam int PHASE_CMDS    = 220;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_reg_e    cfg_index = REG_ORIGIN_LON;
  logic [31:0] cfg_data  = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;  // lon[31:0], lat[62:32], zero[63]
  logic        s_axis_tuser  = CMD_POINT;  // cmd

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;   // px_x[31:0], px_y[63:32]
  logic [1:0]  m_axis_tuser;   // starts_path[0], from_flush[1]

  int err_cnt;
  int pending;
  int painted;
  int flushed;

  int idle_mode    = 0;
  int stall_cycles = 0;
  int cmds_sent    = 0;
  int flushes_sent = 0;
  int cfg_writes   = 0;

  // map edges in force, used to aim the random walks
  logic signed [31:0] cur_origin = RST_ORIGIN_LON;
  logic signed [30:0] cur_top    = RST_TOP_LAT;

  polyline_point_thinning i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  polyline_point_thinning_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .m_user_i    (m_axis_tuser),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .painted_o   (painted),
    .flushed_o   (flushed)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // idle percentage per side: sender busy first, then receiver busy, then none
  function automatic int idle_pct(bit receiver, int mode);
    case (mode)
      0:       return receiver ? 88 : 27;
      1:       return receiver ? 27 : 88;
      default: return 0;
    endcase
  endfunction

  function automatic bit idle_roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= !idle_roll(idle_pct(1'b1, idle_mode));
  end

  // watchdog: cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // one command beat, with random gaps ahead of it; latitude is the low 31 bits of lat
  task automatic send_cmd(cmd_e cmd, logic [31:0] lon, logic [31:0] lat);
    while (idle_roll(idle_pct(1'b0, idle_mode))) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, lat[30:0], lon};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    cmds_sent++;
    if (cmd == CMD_FLUSH) begin
      flushes_sent++;
    end
  endtask

  // drain: every painted point out, then room for a held point still in flight
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write all five map registers, one beat each
  task automatic write_map(logic [31:0] org, logic [31:0] top, logic [31:0] lon_s,
                           logic [31:0] lat_s, logic [31:0] thr);
    logic [31:0] vals [5];
    vals[0] = org;
    vals[1] = top;
    vals[2] = lon_s;
    vals[3] = lat_s;
    vals[4] = thr;
    for (int r = 0; r < 5; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_e'(r);
      cfg_data  <= vals[r];
      do @(posedge clk_i); while (!cfg_ready);
      cfg_writes++;
    end
    cfg_valid  <= 1'b0;
    cur_origin = org;
    cur_top    = top[30:0];
  endtask

  // one ring: a random walk near the map corner, usually closed by a flush
  task automatic run_ring();
    longint lon_w;
    longint lat_w;
    int     len;
    int     k;
    len   = $urandom_range(1, 12);
    k     = $urandom_range(0, 22);
    lon_w = longint'(cur_origin) + longint'($urandom_range(0, 1 << 27));
    lat_w = longint'(cur_top) - longint'($urandom_range(0, 1 << 27));
    repeat (len) begin
      lon_w += longint'($urandom_range(0, 2 << k)) - (longint'(1) << k);
      lat_w += longint'($urandom_range(0, 2 << k)) - (longint'(1) << k);
      send_cmd(CMD_POINT, lon_w[31:0], lat_w[31:0]);
    end
    if ($urandom_range(9) != 0) begin
      send_cmd(CMD_FLUSH, $urandom, $urandom);
    end
  endtask

  // stray commands: wild points, lone and repeated flushes
  task automatic send_noise();
    case ($urandom_range(2))
      0: send_cmd(CMD_POINT, $urandom, $urandom);
      1: send_cmd(CMD_FLUSH, $urandom, $urandom);
      default: begin
        send_cmd(CMD_FLUSH, $urandom, $urandom);
        send_cmd(CMD_FLUSH, $urandom, $urandom);
      end
    endcase
  endtask

  // map setting for one random phase
  task automatic pick_map(int phase);
    case (phase % 3)
      0: begin
        // plausible map: modest scales, threshold near walk step sizes
        write_map($urandom_range(0, 32'd3600000000) - 32'd1800000000,
                  $urandom_range(0, 32'd1800000000) - 32'd900000000,
                  $urandom_range(1 << 20, 1 << 26), $urandom_range(1 << 20, 1 << 26),
                  ($urandom_range(4) == 0) ? 32'd0 : $urandom_range(0, 1 << 20));
      end
      1: begin
        case (phase / 3)
          0:       write_map(-1800000000, 900000000, '1, '1, '1);
          1:       write_map(1800000000, -900000000, '0, '0, '0);
          default: write_map(32'h8000_0000, 32'h4000_0000, 32'd1, '1, 32'd1);
        endcase
      end
      default: write_map($urandom, $urandom, $urandom, $urandom, $urandom);
    endcase
  endtask

  task automatic run_directed();
    // reset map: lone flush, repeat point held then flushed, field extremes
    send_cmd(CMD_FLUSH, '0, '0);
    send_cmd(CMD_POINT, RST_ORIGIN_LON, 32'(RST_TOP_LAT));
    send_cmd(CMD_POINT, RST_ORIGIN_LON, 32'(RST_TOP_LAT));
    send_cmd(CMD_FLUSH, '1, '1);
    send_cmd(CMD_FLUSH, '0, '0);
    send_cmd(CMD_POINT, 32'h7FFF_FFFF, 32'h3FFF_FFFF);
    send_cmd(CMD_POINT, 32'h8000_0000, 32'h4000_0000);
    send_cmd(CMD_POINT, 1800000000, -900000000);
    send_cmd(CMD_POINT, -1800000000, 900000000);
    send_cmd(CMD_POINT, RST_ORIGIN_LON + 20000, 32'(RST_TOP_LAT));
    send_cmd(CMD_FLUSH, '0, '0);
    // half-pixel scale: rounding ties and a threshold met exactly
    settle();
    write_map('0, '0, 32'h8000_0000, 32'h8000_0000, 32'd4);
    send_cmd(CMD_POINT, 0, 0);
    send_cmd(CMD_POINT, 1, 0);
    send_cmd(CMD_POINT, -1, 0);
    send_cmd(CMD_POINT, 4, 0);
    send_cmd(CMD_POINT, 6, 0);
    send_cmd(CMD_POINT, 6, -3);
    send_cmd(CMD_POINT, 6, -3);
    send_cmd(CMD_FLUSH, '0, '0);
    // top threshold: just short of it, just reaching it, large offset
    settle();
    write_map('0, '0, 32'h8000_0000, 32'h8000_0000, '1);
    send_cmd(CMD_POINT, 0, 0);
    send_cmd(CMD_POINT, 131070, 0);
    send_cmd(CMD_POINT, 131072, 0);
    send_cmd(CMD_POINT, 131072, -262144);
    send_cmd(CMD_FLUSH, '0, '0);
  endtask

  initial begin
    int phase_start;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      idle_mode <= phase * 3 / NUM_PHASES;
      pick_map(phase);
      phase_start = cmds_sent;
      while (cmds_sent - phase_start < PHASE_CMDS) begin
        if ($urandom_range(9) < 8) begin
          run_ring();
        end else begin
          send_noise();
        end
      end
    end
    settle();
    $display("covered %0d commands (%0d ring ends) and %0d register writes over %0d maps",
             cmds_sent, flushes_sent, cfg_writes, cfg_writes / 5 + 1);
    $display("%0d points painted, %0d by ring-end flush, %0d mismatches",
             painted, flushed, err_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/ptp_pkg.sv
design/ptp_front.sv
design/ptp_queue.sv
design/ptp_back.sv
design/polyline_point_thinning.sv
design/ptp_checker.sv
dv/polyline_point_thinning_checker.sv
dv/polyline_point_thinning_tb.sv
